FILE: design/ltpg_pkg.sv
// Shared types, constants and constant tables for the LED test pattern generator.
`timescale 1ns / 1ps

package ltpg_pkg;

  // Geometry of the matrix screen and the LED ring
  localparam int SCREEN_COLS = 32;
  localparam int SCREEN_ROWS = 16;
  localparam int RING_COUNT  = 24;

  // Field widths of the input and result words
  localparam int STEP_W = 31;
  localparam int OP_W   = 3;
  localparam int COL_W  = 5;
  localparam int ROW_W  = 4;
  localparam int CH_W   = 8;

  // Datapath width of the constant divider, and of positions on screen or ring (up to 127)
  localparam int DV_W  = 32;
  localparam int POS_W = 7;

  localparam int TOTAL = SCREEN_COLS * SCREEN_ROWS;
  localparam int IDX_W = $clog2(TOTAL);

  // Color wheel and animation rates
  localparam int HUE_RANGE     = 768;
  localparam int HUE_W         = $clog2(HUE_RANGE);
  localparam int FILL_RATE     = 5;
  localparam int FILL_PAD      = 10;
  localparam int RING_HUE_RATE = 20;
  localparam int LEVEL_MAX     = 255;
  localparam int SNAKE_LEN     = 12;
  localparam int SNAKE_FADE    = 220;
  localparam int DIST_W        = $clog2(SNAKE_LEN);

  // Target and pattern codes
  localparam logic TGT_MATRIX = 1'b0;

  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_SNAKE   = 3'd1;
  localparam logic [OP_W-1:0] OP_BOUNCE  = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL    = 3'd3;
  localparam logic [OP_W-1:0] OP_RAINBOW = 3'd4;
  localparam logic [OP_W-1:0] OP_CHASE   = 3'd5;

  // Moduli applied to the step count
  localparam int M_SNK  = TOTAL;                  // matrix snake head
  localparam int M_BX   = 2 * (SCREEN_COLS - 1);  // matrix bounce, x period
  localparam int M_BY   = SCREEN_ROWS - 1;        // matrix bounce, half y period
  localparam int M_FILL = TOTAL + FILL_PAD;       // matrix fill period
  localparam int M_RBW  = HUE_RANGE / 2;          // matrix rainbow, half hue range
  localparam int M_CHS  = SCREEN_COLS;            // matrix chase bar
  localparam int M_RN   = RING_COUNT;             // ring snake and chase head
  localparam int M_RB   = 4 * RING_COUNT;         // ring bounce, before halving
  localparam int M_RF   = RING_COUNT + 4;         // ring fill period
  localparam int M_RR   = HUE_RANGE;              // ring rainbow

  localparam int W_SNK  = $clog2(M_SNK);
  localparam int W_BX   = $clog2(M_BX);
  localparam int W_BY   = $clog2(M_BY);
  localparam int W_FILL = $clog2(M_FILL);
  localparam int W_RBW  = $clog2(M_RBW);
  localparam int W_CHS  = $clog2(M_CHS);
  localparam int W_RN   = $clog2(M_RN);
  localparam int W_RB   = $clog2(M_RB);
  localparam int W_RF   = $clog2(M_RF);
  localparam int W_RR   = $clog2(M_RR);

  // Operand widths of the second division pass
  localparam int V5_W  = $clog2(M_FILL * FILL_RATE);
  localparam int V20_W = $clog2(M_RR * RING_HUE_RATE);
  localparam int VLV_W = $clog2(TOTAL * LEVEL_MAX);

  // Reciprocals floor(2^32 / m): the estimate is exact or one low for any 32-bit dividend
  localparam logic [DV_W-1:0] RCP_SNK  = DV_W'((64'd1 << DV_W) / M_SNK);
  localparam logic [DV_W-1:0] RCP_BX   = DV_W'((64'd1 << DV_W) / M_BX);
  localparam logic [DV_W-1:0] RCP_BY   = DV_W'((64'd1 << DV_W) / M_BY);
  localparam logic [DV_W-1:0] RCP_FILL = DV_W'((64'd1 << DV_W) / M_FILL);
  localparam logic [DV_W-1:0] RCP_RBW  = DV_W'((64'd1 << DV_W) / M_RBW);
  localparam logic [DV_W-1:0] RCP_CHS  = DV_W'((64'd1 << DV_W) / M_CHS);
  localparam logic [DV_W-1:0] RCP_RN   = DV_W'((64'd1 << DV_W) / M_RN);
  localparam logic [DV_W-1:0] RCP_RB   = DV_W'((64'd1 << DV_W) / M_RB);
  localparam logic [DV_W-1:0] RCP_RF   = DV_W'((64'd1 << DV_W) / M_RF);
  localparam logic [DV_W-1:0] RCP_RR   = DV_W'((64'd1 << DV_W) / M_RR);
  localparam logic [DV_W-1:0] RCP_TOT  = DV_W'((64'd1 << DV_W) / TOTAL);

  // Input and result words
  typedef struct packed {
    logic              target;
    logic [OP_W-1:0]   opcode;
    logic [STEP_W-1:0] step;
    logic [COL_W-1:0]  col_or_led;
    logic [ROW_W-1:0]  row;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } out_word_t;

  // Reduced animation phases handed from the divider pipeline to the shader
  typedef struct packed {
    in_word_t          item;
    logic [IDX_W-1:0]  idx;
    logic [W_SNK-1:0]  hs;
    logic [POS_W-1:0]  bx;
    logic [POS_W-1:0]  by;
    logic [POS_W-1:0]  cs;
    logic [POS_W-1:0]  rs;
    logic [POS_W-1:0]  head;
    logic [W_RF-1:0]   rfr;
    logic [W_RBW-1:0]  re;
    logic [W_FILL-1:0] fmod;
    logic [W_RR-1:0]   rr20;
    logic [CH_W-1:0]   lvl;
  } phase_t;

  // Ring hue offset per LED: led * 768 / RING_COUNT
  typedef logic [(1 << COL_W)-1:0][HUE_W-1:0] ring_hue_t;

  function automatic ring_hue_t ring_hue_tab();
    ring_hue_t t;
    for (int i = 0; i < (1 << COL_W); i++) begin
      if (i < RING_COUNT) begin
        t[i] = HUE_W'((i * HUE_RANGE) / RING_COUNT);
      end else begin
        t[i] = '0;
      end
    end
    return t;
  endfunction

  localparam ring_hue_t RING_HUE = ring_hue_tab();

  // Matrix snake green level per tail distance
  typedef logic [(1 << DIST_W)-1:0][CH_W-1:0] snake_tab_t;

  function automatic snake_tab_t snake_tab();
    snake_tab_t t;
    for (int i = 0; i < (1 << DIST_W); i++) begin
      if (i < SNAKE_LEN) begin
        t[i] = CH_W'(LEVEL_MAX - (i * SNAKE_FADE) / SNAKE_LEN);
      end else begin
        t[i] = '0;
      end
    end
    return t;
  endfunction

  localparam snake_tab_t SNAKE_GREEN = snake_tab();

endpackage

FILE: design/ltpg_cmod.sv
// Three-stage divider by a constant: reciprocal multiply, remainder, one correction.
`timescale 1ns / 1ps

module ltpg_cmod import ltpg_pkg::*; (
  input  logic            clk,
  input  logic [DV_W-1:0] val,
  input  logic [DV_W-1:0] recip,
  input  logic [DV_W-1:0] modulus,
  output logic [DV_W-1:0] quo,
  output logic [DV_W-1:0] rem
);

  localparam int PW = 2 * DV_W;

  logic [PW-1:0]   prod_r;
  logic [DV_W-1:0] val_r;
  logic [DV_W-1:0] quo_est_r, rem_est_r;
  logic [DV_W-1:0] quo_est_nxt, rem_est_nxt;
  logic [DV_W-1:0] quo_r, rem_r;
  logic [DV_W-1:0] quo_nxt, rem_nxt;

  // Estimate the quotient, then form a remainder below twice the modulus
  always_comb begin
    quo_est_nxt = prod_r[PW-1:DV_W];
    rem_est_nxt = val_r - DV_W'(quo_est_nxt * modulus);
  end

  // Fix an estimate that came out one low
  always_comb begin
    if (rem_est_r >= modulus) begin
      quo_nxt = quo_est_r + DV_W'(1);
      rem_nxt = rem_est_r - modulus;
    end else begin
      quo_nxt = quo_est_r;
      rem_nxt = rem_est_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= PW'(val) * PW'(recip);
    val_r     <= val;
    quo_est_r <= quo_est_nxt;
    rem_est_r <= rem_est_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

FILE: design/ltpg_phase.sv
// Divider pipeline: reduces the step count to every animation phase the patterns need.
`timescale 1ns / 1ps

module ltpg_phase import ltpg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_word_t in_word,
  output logic     ph_valid,
  output phase_t   ph
);

  localparam int DLY = 3;

  logic [DV_W-1:0] step_ext;
  logic [DV_W-1:0] rem_snk, rem_bx, rem_by, rem_fill, rem_rbw;
  logic [DV_W-1:0] rem_chs, rem_rn, rem_rb, rem_rf, rem_rr;
  logic [DV_W-1:0] rem_f5, rem_r20, quo_lvl;

  logic [DLY-1:0] v_g1_r;
  in_word_t       item_g1_r [DLY];

  phase_t           comb_nxt, comb_r;
  logic [V5_W-1:0]  v5_nxt, v5_r;
  logic [V20_W-1:0] v20_nxt, v20_r;
  logic [VLV_W-1:0] vlv_nxt, vlv_r;
  logic             v_comb_r;

  logic [DLY-1:0] v_g2_r;
  phase_t         ph_d_r [DLY];

  logic [POS_W-1:0] bx_raw, by_raw, h_raw;

  assign step_ext = DV_W'(in_word.step);

  // First pass: step count modulo each pattern period
  ltpg_cmod u_snk (.clk(clk), .val(step_ext), .recip(RCP_SNK), .modulus(DV_W'(M_SNK)),
                   .quo(), .rem(rem_snk));
  ltpg_cmod u_bx (.clk(clk), .val(step_ext), .recip(RCP_BX), .modulus(DV_W'(M_BX)),
                  .quo(), .rem(rem_bx));
  ltpg_cmod u_by (.clk(clk), .val(step_ext), .recip(RCP_BY), .modulus(DV_W'(M_BY)),
                  .quo(), .rem(rem_by));
  ltpg_cmod u_fill (.clk(clk), .val(step_ext), .recip(RCP_FILL), .modulus(DV_W'(M_FILL)),
                    .quo(), .rem(rem_fill));
  ltpg_cmod u_rbw (.clk(clk), .val(step_ext), .recip(RCP_RBW), .modulus(DV_W'(M_RBW)),
                   .quo(), .rem(rem_rbw));
  ltpg_cmod u_chs (.clk(clk), .val(step_ext), .recip(RCP_CHS), .modulus(DV_W'(M_CHS)),
                   .quo(), .rem(rem_chs));
  ltpg_cmod u_rn (.clk(clk), .val(step_ext), .recip(RCP_RN), .modulus(DV_W'(M_RN)),
                  .quo(), .rem(rem_rn));
  ltpg_cmod u_rb (.clk(clk), .val(step_ext), .recip(RCP_RB), .modulus(DV_W'(M_RB)),
                  .quo(), .rem(rem_rb));
  ltpg_cmod u_rf (.clk(clk), .val(step_ext), .recip(RCP_RF), .modulus(DV_W'(M_RF)),
                  .quo(), .rem(rem_rf));
  ltpg_cmod u_rr (.clk(clk), .val(step_ext), .recip(RCP_RR), .modulus(DV_W'(M_RR)),
                  .quo(), .rem(rem_rr));

  // Fold the bounce positions and scale the phases for the second pass
  always_comb begin
    bx_raw = POS_W'(rem_bx[W_BX-1:0]);
    by_raw = POS_W'({rem_by[W_BY-1:0], 1'b0});
    h_raw  = POS_W'(rem_rb[W_RB-1:1]);

    comb_nxt      = '0;
    comb_nxt.item = item_g1_r[DLY-1];
    comb_nxt.idx  = IDX_W'(int'(item_g1_r[DLY-1].row) * SCREEN_COLS
                           + int'(item_g1_r[DLY-1].col_or_led));
    comb_nxt.hs   = rem_snk[W_SNK-1:0];
    comb_nxt.bx   = (bx_raw >= POS_W'(SCREEN_COLS)) ? POS_W'(M_BX) - bx_raw : bx_raw;
    comb_nxt.by   = (by_raw >= POS_W'(SCREEN_ROWS)) ? POS_W'(2 * M_BY) - by_raw : by_raw;
    comb_nxt.cs   = POS_W'(rem_chs[W_CHS-1:0]);
    comb_nxt.rs   = POS_W'(rem_rn[W_RN-1:0]);
    comb_nxt.head = (h_raw >= POS_W'(RING_COUNT)) ? POS_W'(2 * RING_COUNT) - h_raw : h_raw;
    comb_nxt.rfr  = rem_rf[W_RF-1:0];
    comb_nxt.re   = rem_rbw[W_RBW-1:0];

    v5_nxt  = V5_W'(rem_fill[W_FILL-1:0]) * V5_W'(FILL_RATE);
    v20_nxt = V20_W'(rem_rr[W_RR-1:0]) * V20_W'(RING_HUE_RATE);
    vlv_nxt = VLV_W'(comb_nxt.idx) * VLV_W'(LEVEL_MAX);
  end

  // Second pass: scaled phases modulo their periods, and the grey fill level
  ltpg_cmod u_f5 (.clk(clk), .val(DV_W'(v5_r)), .recip(RCP_FILL), .modulus(DV_W'(M_FILL)),
                  .quo(), .rem(rem_f5));
  ltpg_cmod u_r20 (.clk(clk), .val(DV_W'(v20_r)), .recip(RCP_RR), .modulus(DV_W'(M_RR)),
                   .quo(), .rem(rem_r20));
  ltpg_cmod u_lvl (.clk(clk), .val(DV_W'(vlv_r)), .recip(RCP_TOT), .modulus(DV_W'(TOTAL)),
                   .quo(quo_lvl), .rem());

  // Advance valid bits alongside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g1_r   <= '0;
      v_comb_r <= 1'b0;
      v_g2_r   <= '0;
    end else begin
      v_g1_r   <= {v_g1_r[DLY-2:0], in_valid};
      v_comb_r <= v_g1_r[DLY-1];
      v_g2_r   <= {v_g2_r[DLY-2:0], v_comb_r};
    end
  end

  // Carry payload through the same stages
  always_ff @(posedge clk) begin
    item_g1_r[0] <= in_word;
    for (int i = 1; i < DLY; i++) begin
      item_g1_r[i] <= item_g1_r[i-1];
    end
    comb_r    <= comb_nxt;
    v5_r      <= v5_nxt;
    v20_r     <= v20_nxt;
    vlv_r     <= vlv_nxt;
    ph_d_r[0] <= comb_r;
    for (int i = 1; i < DLY; i++) begin
      ph_d_r[i] <= ph_d_r[i-1];
    end
  end

  // Merge the second-pass results into the phase word
  always_comb begin
    ph      = ph_d_r[DLY-1];
    ph.fmod = rem_f5[W_FILL-1:0];
    ph.rr20 = rem_r20[W_RR-1:0];
    ph.lvl  = quo_lvl[CH_W-1:0];
  end

  assign ph_valid = v_g2_r[DLY-1];

endmodule

FILE: design/ltpg_shade.sv
// Shader: picks the pattern hit for the pixel, then maps it to an RGB word.
`timescale 1ns / 1ps

module ltpg_shade import ltpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      ph_valid,
  input  phase_t    ph,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int RING_SNAKE_LEN = 6;
  localparam int RING_CHASE_LEN = 4;
  localparam int BAR_LEN        = 3;
  localparam int SUM_W          = HUE_W + 1;

  localparam logic [CH_W-1:0] FULL        = 8'd255;
  localparam logic [CH_W-1:0] BOUNCE_NEAR = 8'd120;
  localparam logic [CH_W-1:0] RING_FILL   = 8'd200;
  localparam logic [CH_W-1:0] STEP_80     = 8'd80;
  localparam logic [CH_W-1:0] STEP_60     = 8'd60;
  localparam logic [CH_W-1:0] STEP_40     = 8'd40;

  localparam logic [HUE_W-1:0] SEG_1    = 10'd256;
  localparam logic [HUE_W-1:0] SEG_2    = 10'd512;
  localparam logic [HUE_W-1:0] SEG_1END = 10'd511;
  localparam logic [HUE_W-1:0] SEG_2END = 10'd767;
  localparam logic [HUE_W-1:0] SEG_0END = 10'd255;

  typedef enum logic [3:0] {
    K_BLACK,
    K_MSNAKE,
    K_MBOUNCE,
    K_GREY,
    K_WHEEL,
    K_MCHASE,
    K_RSNAKE,
    K_RBOUNCE,
    K_RFILL,
    K_RCHASE
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [DIST_W-1:0] tail;
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   lvl;
  } shd_t;

  function automatic logic [POS_W-1:0] pos_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  shd_t      s1_nxt, s1_r;
  logic      v1_r, v2_r;
  out_word_t out_nxt, out_r;

  logic [POS_W-1:0] col_p, row_p;
  logic [IDX_W:0]   snk_d;
  logic [POS_W-1:0] man, cd, ring_d, bd;
  logic [POS_W:0]   rthr;
  logic [SUM_W-1:0] mhue, rhue;
  logic             in_mat, in_ring;

  // Distances and hues for both targets
  always_comb begin
    col_p   = POS_W'(ph.item.col_or_led);
    row_p   = POS_W'(ph.item.row);
    in_mat  = (int'(ph.item.col_or_led) < SCREEN_COLS) && (int'(ph.item.row) < SCREEN_ROWS);
    in_ring = int'(ph.item.col_or_led) < RING_COUNT;

    if (ph.hs >= ph.idx) begin
      snk_d = (IDX_W+1)'(ph.hs) - (IDX_W+1)'(ph.idx);
    end else begin
      snk_d = (IDX_W+1)'(ph.hs) + (IDX_W+1)'(TOTAL) - (IDX_W+1)'(ph.idx);
    end

    man = pos_diff(col_p, ph.bx) + pos_diff(row_p, ph.by);
    cd  = pos_diff(col_p, ph.cs);

    mhue = SUM_W'(col_p) + SUM_W'(row_p) + SUM_W'({ph.re, 1'b0});
    if (mhue >= SUM_W'(HUE_RANGE)) begin
      mhue = mhue - SUM_W'(HUE_RANGE);
    end

    if (ph.rs >= col_p) begin
      ring_d = ph.rs - col_p;
    end else begin
      ring_d = ph.rs + POS_W'(RING_COUNT) - col_p;
    end
    bd = pos_diff(ph.head, col_p);

    rthr = (POS_W+1)'({ph.rfr, 1'b0});
    if (rthr >= (POS_W+1)'(M_RF)) begin
      rthr = rthr - (POS_W+1)'(M_RF);
    end

    rhue = SUM_W'(RING_HUE[ph.item.col_or_led]) + SUM_W'(ph.rr20);
    if (rhue >= SUM_W'(HUE_RANGE)) begin
      rhue = rhue - SUM_W'(HUE_RANGE);
    end
  end

  // Select what the pattern draws at this pixel
  always_comb begin
    s1_nxt      = '0;
    s1_nxt.kind = K_BLACK;
    if (ph.item.target == TGT_MATRIX) begin
      if (in_mat) begin
        unique case (ph.item.opcode)
          OP_NONE: s1_nxt.kind = K_BLACK;
          OP_SNAKE: begin
            if (snk_d < (IDX_W+1)'(SNAKE_LEN)) begin
              s1_nxt.kind = K_MSNAKE;
              s1_nxt.tail = DIST_W'(snk_d);
            end
          end
          OP_BOUNCE: begin
            if (man < POS_W'(2)) begin
              s1_nxt.kind = K_MBOUNCE;
              s1_nxt.tail = DIST_W'(man);
            end
          end
          OP_FILL: begin
            if (int'(ph.idx) < int'(ph.fmod)) begin
              s1_nxt.kind = K_GREY;
              s1_nxt.lvl  = ph.lvl;
            end
          end
          OP_RAINBOW: begin
            s1_nxt.kind = K_WHEEL;
            s1_nxt.hue  = HUE_W'(mhue);
          end
          OP_CHASE: begin
            if (cd < POS_W'(BAR_LEN)) begin
              s1_nxt.kind = K_MCHASE;
              s1_nxt.tail = DIST_W'(cd);
            end
          end
          default: s1_nxt.kind = K_BLACK;
        endcase
      end
    end else begin
      if (in_ring) begin
        unique case (ph.item.opcode)
          OP_NONE: s1_nxt.kind = K_BLACK;
          OP_SNAKE: begin
            if (ring_d < POS_W'(RING_SNAKE_LEN)) begin
              s1_nxt.kind = K_RSNAKE;
              s1_nxt.tail = DIST_W'(ring_d);
            end
          end
          OP_BOUNCE: begin
            if (bd < POS_W'(BAR_LEN)) begin
              s1_nxt.kind = K_RBOUNCE;
              s1_nxt.tail = DIST_W'(bd);
            end
          end
          OP_FILL: begin
            if ((POS_W+1)'(col_p) < rthr) begin
              s1_nxt.kind = K_RFILL;
            end
          end
          OP_RAINBOW: begin
            s1_nxt.kind = K_WHEEL;
            s1_nxt.hue  = HUE_W'(rhue);
          end
          OP_CHASE: begin
            if (ring_d < POS_W'(RING_CHASE_LEN)) begin
              s1_nxt.kind = K_RCHASE;
              s1_nxt.tail = DIST_W'(ring_d);
            end
          end
          default: s1_nxt.kind = K_BLACK;
        endcase
      end
    end
  end

  // Map the selection to a color word
  always_comb begin
    out_nxt = '0;
    unique case (s1_r.kind)
      K_BLACK: out_nxt = '0;
      K_MSNAKE: out_nxt.green = SNAKE_GREEN[s1_r.tail];
      K_MBOUNCE: out_nxt.red = (s1_r.tail == '0) ? FULL : BOUNCE_NEAR;
      K_GREY: begin
        out_nxt.red   = s1_r.lvl;
        out_nxt.green = s1_r.lvl;
        out_nxt.blue  = s1_r.lvl;
      end
      K_WHEEL: begin
        if (s1_r.hue < SEG_1) begin
          out_nxt.red   = CH_W'(SEG_0END - s1_r.hue);
          out_nxt.green = CH_W'(s1_r.hue);
        end else if (s1_r.hue < SEG_2) begin
          out_nxt.green = CH_W'(SEG_1END - s1_r.hue);
          out_nxt.blue  = CH_W'(s1_r.hue - SEG_1);
        end else begin
          out_nxt.red  = CH_W'(s1_r.hue - SEG_2);
          out_nxt.blue = CH_W'(SEG_2END - s1_r.hue);
        end
      end
      K_MCHASE: begin
        out_nxt.red   = FULL - CH_W'(CH_W'(s1_r.tail) * STEP_80);
        out_nxt.green = out_nxt.red >> 1;
      end
      K_RSNAKE: out_nxt.green = FULL - CH_W'(CH_W'(s1_r.tail) * STEP_40);
      K_RBOUNCE: out_nxt.red = FULL - CH_W'(CH_W'(s1_r.tail) * STEP_80);
      K_RFILL: begin
        out_nxt.red   = RING_FILL;
        out_nxt.green = RING_FILL;
      end
      K_RCHASE: begin
        out_nxt.red   = FULL - CH_W'(CH_W'(s1_r.tail) * STEP_60);
        out_nxt.green = out_nxt.red >> 1;
      end
      default: out_nxt = '0;
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ph_valid;
      v2_r <= v1_r;
    end
  end

  // Hold payload stages
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = v2_r;
  assign out_word  = out_r;

endmodule

FILE: design/led_test_pattern_generator_unit.sv
// Top level of the LED test pattern generator: divider pipeline followed by the shader.
`timescale 1ns / 1ps

// Per-pixel test pattern generator for a matrix screen or an LED ring. One pixel
// word is taken on every clock where start is high; busy never rises, so words may
// be issued back to back without gaps. Each word yields exactly one color word on
// out_word, flagged by a one-cycle out_strobe, in issue order. The path from the
// accepting edge to out_strobe runs through nine register stages: two chained
// constant-division passes (reciprocal multiply, remainder, correction: three stages
// each, the first loading on the accepting edge) that reduce the step count to each
// pattern's phase, one register stage that folds and scales the phases between the
// passes, and two shading stages. There is no state to clear after reset and no
// configuration.

module led_test_pattern_generator_unit import ltpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_strobe,
  output out_word_t out_word
);

  logic   in_accept;
  logic   ph_valid;
  phase_t ph;

  // Always ready: the pipeline advances every cycle
  assign busy      = 1'b0;
  assign in_accept = start & ~busy;

  ltpg_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_accept),
    .in_word (in_word),
    .ph_valid(ph_valid),
    .ph      (ph)
  );

  ltpg_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .ph_valid (ph_valid),
    .ph       (ph),
    .out_valid(out_strobe),
    .out_word (out_word)
  );

endmodule

FILE: test/led_test_pattern_generator_unit_tb.sv
// Self-checking testbench for the LED test pattern generator: directed table, then random pixel words.
`timescale 1ns / 1ps

module led_test_pattern_generator_unit_tb;
  import ltpg_pkg::*;

  localparam logic            TGT_RING  = ~TGT_MATRIX;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
  localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
  localparam int RANDOM_WORDS = 1600;

  // One row of the directed table; known rows carry a hand-written color
  typedef struct {
    in_word_t  pix;
    bit        known;
    out_word_t color;
  } pixel_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  out_word_t  color_q[$];
  pixel_row_t pixel_rows[$];
  out_word_t  color_exp;
  int         errors;

  led_test_pattern_generator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Triangle wave position over 2*(n-1) steps
  function automatic longint unsigned bounce_pos(longint unsigned v, longint unsigned n);
    longint unsigned p;
    longint unsigned x;
    p = 2 * (n - 1);
    x = v % p;
    if (x >= n) x = p - x;
    return x;
  endfunction

  function automatic longint unsigned span(longint unsigned a, longint unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Three-segment color wheel over 768 hues
  function automatic out_word_t hue_color(longint unsigned h);
    out_word_t c;
    if (h < 256) begin
      c.red = CH_W'(255 - h); c.green = CH_W'(h); c.blue = '0;
    end else if (h < 512) begin
      c.red = '0; c.green = CH_W'(511 - h); c.blue = CH_W'(h - 256);
    end else begin
      c.red = CH_W'(h - 512); c.green = '0; c.blue = CH_W'(767 - h);
    end
    return c;
  endfunction

  // Color that the selected pattern leaves at one pixel
  function automatic out_word_t pixel_color(in_word_t w);
    longint unsigned s, x, y, idx, d, hd, man, lvl;
    out_word_t c;
    c = '0;
    s = w.step;
    x = w.col_or_led;
    y = w.row;
    if (w.target == TGT_MATRIX) begin
      if (x < SCREEN_COLS && y < SCREEN_ROWS) begin
        idx = y * SCREEN_COLS + x;
        case (w.opcode)
          OP_SNAKE: begin
            d = (s % TOTAL + TOTAL - idx) % TOTAL;
            if (d < SNAKE_LEN) c.green = CH_W'(LEVEL_MAX - d * SNAKE_FADE / SNAKE_LEN);
          end
          OP_BOUNCE: begin
            man = span(x, bounce_pos(s, SCREEN_COLS)) + span(y, bounce_pos(2 * s, SCREEN_ROWS));
            if (man == 0) c.red = 8'd255;
            else if (man == 1) c.red = 8'd120;
          end
          OP_FILL: begin
            if (idx < (s * FILL_RATE) % (TOTAL + FILL_PAD)) begin
              lvl = idx * LEVEL_MAX / TOTAL;
              c = '{CH_W'(lvl), CH_W'(lvl), CH_W'(lvl)};
            end
          end
          OP_RAINBOW: c = hue_color((x + y + 2 * s) % HUE_RANGE);
          OP_CHASE: begin
            d = span(x, s % SCREEN_COLS);
            if (d < 3) begin
              c.red = CH_W'(255 - 80 * d);
              c.green = c.red >> 1;
            end
          end
          default: c = '0;
        endcase
      end
    end else if (x < RING_COUNT) begin
      d = (s % RING_COUNT + RING_COUNT - x) % RING_COUNT;
      case (w.opcode)
        OP_SNAKE: if (d < 6) c.green = CH_W'(255 - 40 * d);
        OP_BOUNCE: begin
          hd = (s / 2) % (2 * RING_COUNT);
          if (hd >= RING_COUNT) hd = 2 * RING_COUNT - hd;
          d = span(hd, x);
          if (d < 3) c.red = CH_W'(255 - 80 * d);
        end
        OP_FILL: if (x < (2 * s) % (RING_COUNT + 4)) begin
          c.red = 8'd200;
          c.green = 8'd200;
        end
        OP_RAINBOW: c = hue_color((x * HUE_RANGE / RING_COUNT + RING_HUE_RATE * s) % HUE_RANGE);
        OP_CHASE: if (d < 4) begin
          c.red = CH_W'(255 - 60 * d);
          c.green = c.red >> 1;
        end
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  // Move the pixel next to the pattern head so aimed random words often land on drawn pixels
  function automatic in_word_t aim_pixel(in_word_t w);
    longint unsigned s, idx, hd, pos;
    s = w.step;
    if (w.target == TGT_MATRIX) begin
      idx = {w.row, w.col_or_led};
      case (w.opcode)
        OP_SNAKE: idx = (s % TOTAL + TOTAL - $urandom_range(0, 13)) % TOTAL;
        OP_FILL: idx = ((s * FILL_RATE) % (TOTAL + FILL_PAD) + TOTAL - 2 + $urandom_range(0, 3))
                       % TOTAL;
        OP_BOUNCE: begin
          w.col_or_led = COL_W'(bounce_pos(s, SCREEN_COLS) + SCREEN_COLS - 1 + $urandom_range(0, 2));
          w.row = ROW_W'(bounce_pos(2 * s, SCREEN_ROWS) + SCREEN_ROWS - 1 + $urandom_range(0, 2));
          idx = {w.row, w.col_or_led};
        end
        OP_CHASE: idx = {w.row, COL_W'(s % SCREEN_COLS + SCREEN_COLS - 3 + $urandom_range(0, 6))};
        default: idx = {w.row, w.col_or_led};
      endcase
      {w.row, w.col_or_led} = (ROW_W + COL_W)'(idx);
    end else begin
      pos = w.col_or_led;
      case (w.opcode)
        OP_SNAKE, OP_CHASE: pos = (s % RING_COUNT + RING_COUNT - $urandom_range(0, 6)) % RING_COUNT;
        OP_BOUNCE: begin
          hd = (s / 2) % (2 * RING_COUNT);
          if (hd >= RING_COUNT) hd = 2 * RING_COUNT - hd;
          pos = hd + 32 - 3 + $urandom_range(0, 6);
        end
        OP_FILL: pos = (2 * s) % (RING_COUNT + 4) + 32 - 2 + $urandom_range(0, 3);
        default: pos = w.col_or_led;
      endcase
      w.col_or_led = COL_W'(pos);
    end
    return w;
  endfunction

  task automatic add_row(input logic tgt, input logic [OP_W-1:0] op,
                         input logic [STEP_W-1:0] stp, input int col, input int row,
                         input bit known, input int r, input int g, input int b);
    pixel_row_t pr;
    pr.pix = '{tgt, op, stp, COL_W'(col), ROW_W'(row)};
    pr.known = known;
    pr.color = '{CH_W'(r), CH_W'(g), CH_W'(b)};
    pixel_rows.push_back(pr);
  endtask

  // Drive one word and hold it until the block takes it
  task automatic send_word(input in_word_t w, input bit known, input out_word_t color);
    @(negedge clk);
    in_word <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    color_q.push_back(known ? color : pixel_color(w));
  endtask

  // Drop start for a random number of cycles, about 31 in a hundred
  task automatic sender_gap();
    while ($urandom_range(0, 99) < 31) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Check every color word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (color_q.size() == 0) begin
        errors++;
        $display("%0t: color word %h with none expected", $time, out_word);
      end else begin
        color_exp = color_q.pop_front();
        if (out_word.red !== color_exp.red || out_word.green !== color_exp.green ||
            out_word.blue !== color_exp.blue) begin
          errors++;
          $display("%0t: color mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                   $time, color_exp.red, color_exp.green, color_exp.blue,
                   out_word.red, out_word.green, out_word.blue);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("led_test_pattern_generator_unit_tb failed");
    $finish;
  end

  initial begin
    in_word_t w;
    int wait_cycles;
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;

    // Directed rows: every pattern on both targets, extremes and black cases
    add_row(TGT_MATRIX, OP_NONE, '0, 0, 0, 1, 0, 0, 0);
    add_row(TGT_MATRIX, OP_NONE, STEP_MAX, 31, 15, 1, 0, 0, 0);
    add_row(TGT_MATRIX, OP_SNAKE, '0, 0, 0, 1, 0, 255, 0);
    add_row(TGT_MATRIX, OP_SNAKE, STEP_MAX, 31, 15, 0, 0, 0, 0);
    add_row(TGT_MATRIX, OP_BOUNCE, '0, 0, 0, 1, 255, 0, 0);
    add_row(TGT_MATRIX, OP_BOUNCE, '0, 1, 0, 1, 120, 0, 0);
    add_row(TGT_MATRIX, OP_BOUNCE, STEP_MAX, 31, 15, 0, 0, 0, 0);
    add_row(TGT_MATRIX, OP_FILL, '0, 0, 0, 1, 0, 0, 0);
    add_row(TGT_MATRIX, OP_FILL, 31'd104, 31, 15, 0, 0, 0, 0);
    add_row(TGT_MATRIX, OP_RAINBOW, '0, 0, 0, 1, 255, 0, 0);
    add_row(TGT_MATRIX, OP_RAINBOW, STEP_MAX, 31, 15, 0, 0, 0, 0);
    add_row(TGT_MATRIX, OP_CHASE, '0, 0, 0, 1, 255, 127, 0);
    add_row(TGT_MATRIX, OP_CHASE, '0, 2, 7, 0, 0, 0, 0);
    add_row(TGT_MATRIX, OP_SPARE6, '0, 0, 0, 1, 0, 0, 0);
    add_row(TGT_MATRIX, OP_SPARE7, '0, 0, 0, 1, 0, 0, 0);
    add_row(TGT_RING, OP_SNAKE, '0, 0, 15, 1, 0, 255, 0);
    add_row(TGT_RING, OP_BOUNCE, '0, 0, 0, 1, 255, 0, 0);
    add_row(TGT_RING, OP_BOUNCE, 31'd48, 23, 0, 0, 0, 0, 0);
    add_row(TGT_RING, OP_BOUNCE, STEP_MAX, 22, 0, 0, 0, 0, 0);
    add_row(TGT_RING, OP_FILL, 31'd13, 23, 0, 0, 0, 0, 0);
    add_row(TGT_RING, OP_RAINBOW, STEP_MAX, 23, 0, 0, 0, 0, 0);
    add_row(TGT_RING, OP_CHASE, '0, 0, 0, 1, 255, 127, 0);
    add_row(TGT_RING, OP_SNAKE, '0, 24, 0, 1, 0, 0, 0);
    add_row(TGT_RING, OP_RAINBOW, STEP_MAX, 31, 15, 1, 0, 0, 0);
    add_row(TGT_RING, OP_SPARE7, '0, 0, 0, 1, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (pixel_rows[i]) begin
      send_word(pixel_rows[i].pix, pixel_rows[i].known, pixel_rows[i].color);
      sender_gap();
    end

    // Random words: mostly valid patterns, about half aimed at the head, some spare opcodes
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w.target = 1'($urandom);
      w.opcode = ($urandom_range(0, 9) == 0) ? OP_W'($urandom_range(6, 7))
                                            : OP_W'($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0, 1: w.step = STEP_W'($urandom_range(0, 2000));
        2: w.step = STEP_MAX - STEP_W'($urandom_range(0, 1000));
        default: w.step = STEP_W'($urandom);
      endcase
      w.col_or_led = COL_W'($urandom);
      w.row = ROW_W'($urandom);
      if ($urandom_range(0, 1) == 1) w = aim_pixel(w);
      send_word(w, 1'b0, '0);

      // Hold off the sender until the pipeline drains
      if (n == 1200) begin
        @(negedge clk);
        start <= 1'b0;
        while (color_q.size() != 0) @(posedge clk);
      end
      // Keep a long back-to-back stretch without gaps
      if (n < 600 || n > 900) sender_gap();
    end

    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (color_q.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);

    if (errors == 0 && color_q.size() == 0) begin
      $display("led_test_pattern_generator_unit_tb passed");
    end else begin
      $display("led_test_pattern_generator_unit_tb failed");
    end
    $finish;
  end

endmodule
